>>> hdl/cdq_pkg.sv
// shared types, codes and sizes of the circular deque
package cdq_pkg;

  localparam int CDQ_DEPTH      = 64;
  localparam int CDQ_DATA_WIDTH = 32;

  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int VAL_W     = 32;
  localparam int FIDX_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_REG_W = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CAP_REG_W-1:0] CAP_REG_RST = 7'd64;
  localparam logic [0:0]           REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5,
    CMD_SEARCH     = 3'd6,
    CMD_CLEAR      = 3'd7
  } cdq_cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } cdq_stat_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } cdq_state_e_t;

endpackage

>>> hdl/cdq_intf.sv
// command and result channel interfaces of the circular deque
interface cdq_cmd_if import cdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cdq_cmd_e_t              command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface cdq_res_if import cdq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cdq_stat_e_t             status;
  logic signed [VAL_W-1:0] data;
  logic [FIDX_W-1:0]       found_index;
  logic [CNT_OUT_W-1:0]    count;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, output status, output data, output found_index,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data, input found_index,
                  input count, input is_empty, input is_full, output ready);
endinterface

>>> hdl/cdq_ring_mem.sv
// ring store: one write port, one read port with registered read data
module cdq_ring_mem import cdq_pkg::*; #(
  parameter int DEPTH      = CDQ_DEPTH,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cdq_index_unit.sv
// shared ring index stepper: one step forward or back with wrap at the capacity
module cdq_index_unit import cdq_pkg::*; #(
  parameter int DEPTH = CDQ_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic [IDX_W-1:0] idx,
  input  logic             dec,
  input  logic [IDX_W-1:0] last,
  output logic [IDX_W-1:0] step_idx
);

  always_comb begin
    if (dec) begin
      step_idx = (idx == '0) ? last : idx - IDX_W'(1);
    end else begin
      step_idx = (idx == last) ? '0 : idx + IDX_W'(1);
    end
  end

endmodule

>>> hdl/cdq_seq.sv
// command sequencer: deque indices, search walk and result register
module cdq_seq import cdq_pkg::*; #(
  parameter int DEPTH      = CDQ_DEPTH,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH,
  parameter int IDX_W      = $clog2(DEPTH),
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cap,
  input  logic [IDX_W-1:0] cap_last,
  input  logic             clr,
  cdq_cmd_if.sink          in_ch,
  cdq_res_if.source        out_ch
);

  cdq_state_e_t state_r, state_nxt;

  logic [IDX_W-1:0]      front_r, rear_r, scan_idx_r, pend_idx_r;
  logic [CNT_W-1:0]      cnt_r, issued_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic                  pend_r;
  cdq_stat_e_t           res_status_r;
  logic                  res_rd_r;
  logic [IDX_W-1:0]      res_found_r;

  logic                    out_valid_r;
  cdq_stat_e_t             out_status_r;
  logic signed [VAL_W-1:0] out_data_r;
  logic [FIDX_W-1:0]       out_found_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic                    out_empty_r, out_full_r;

  logic                  accept, full, empty, hit, scan_done, load_out;
  logic                  in_ready, scan_re;
  logic [IDX_W-1:0]      iu_idx, iu_step;
  logic                  iu_dec;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata, word;
  cdq_stat_e_t           acc_status;
  logic                  acc_rd;

  assign accept    = in_ch.valid && in_ch.ready;
  assign full      = cnt_r >= cap;
  assign empty     = cnt_r == '0;
  assign word      = DATA_WIDTH'($unsigned(in_ch.value));
  assign hit       = pend_r && (mem_rdata == key_r);
  assign scan_done = !pend_r && (issued_r == cnt_r);
  assign load_out  = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  cdq_index_unit #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_index (
    .idx      (iu_idx),
    .dec      (iu_dec),
    .last     (cap_last),
    .step_idx (iu_step)
  );

  cdq_ring_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (word),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.command == CMD_SEARCH && !empty) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (hit || scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    scan_re  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: scan_re  = (issued_r != cnt_r) && !hit;
      ST_RESP: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // status and read need of the command being accepted
  always_comb begin
    acc_status = STAT_OK;
    acc_rd     = 1'b0;
    case (in_ch.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (full) acc_status = STAT_FULL;
      end
      CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (empty) acc_status = STAT_EMPTY;
        acc_rd = !empty;
      end
      CMD_SEARCH: acc_status = STAT_MISS;
      default: ;
    endcase
  end

  // the index unit serves the walk while scanning, else the accepted command
  always_comb begin
    iu_idx = front_r;
    iu_dec = 1'b0;
    if (state_r == ST_SCAN) begin
      iu_idx = scan_idx_r;
    end else begin
      case (in_ch.command) inside
        CMD_PUSH_FRONT:              iu_dec = 1'b1;
        CMD_PUSH_REAR:               iu_idx = rear_r;
        CMD_POP_REAR, CMD_PEEK_REAR: begin
          iu_idx = rear_r;
          iu_dec = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we    = accept && !full &&
                (in_ch.command == CMD_PUSH_FRONT || in_ch.command == CMD_PUSH_REAR);
    mem_waddr = (in_ch.command == CMD_PUSH_FRONT) ? iu_step : rear_r;
    if (state_r == ST_SCAN) begin
      mem_re    = scan_re;
      mem_raddr = scan_idx_r;
    end else begin
      mem_re    = accept && acc_rd;
      mem_raddr = (in_ch.command == CMD_POP_FRONT || in_ch.command == CMD_PEEK_FRONT) ?
                  front_r : iu_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (clr) begin
        front_r <= '0;
        rear_r  <= '0;
        cnt_r   <= '0;
      end else if (accept) begin
        unique case (in_ch.command)
          CMD_PUSH_FRONT: if (!full) begin
            front_r <= iu_step;
            cnt_r   <= cnt_r + CNT_W'(1);
          end
          CMD_PUSH_REAR: if (!full) begin
            rear_r <= iu_step;
            cnt_r  <= cnt_r + CNT_W'(1);
          end
          CMD_POP_FRONT: if (!empty) begin
            front_r <= iu_step;
            cnt_r   <= cnt_r - CNT_W'(1);
          end
          CMD_POP_REAR: if (!empty) begin
            rear_r <= iu_step;
            cnt_r  <= cnt_r - CNT_W'(1);
          end
          CMD_CLEAR: begin
            front_r <= '0;
            rear_r  <= '0;
            cnt_r   <= '0;
          end
          CMD_PEEK_FRONT, CMD_PEEK_REAR, CMD_SEARCH: ;
        endcase
      end

      if (accept) begin
        pend_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        pend_r <= scan_re;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= acc_status;
      res_rd_r     <= acc_rd;
      res_found_r  <= '0;
      key_r        <= word;
      scan_idx_r   <= front_r;
      issued_r     <= '0;
    end else if (state_r == ST_SCAN) begin
      if (scan_re) begin
        scan_idx_r <= iu_step;
        issued_r   <= issued_r + CNT_W'(1);
        pend_idx_r <= scan_idx_r;
      end
      if (hit) begin
        res_status_r <= STAT_OK;
        res_found_r  <= pend_idx_r;
      end
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_rd_r ? VAL_W'($signed(mem_rdata)) : '0;
      out_found_r  <= FIDX_W'(res_found_r);
      out_count_r  <= CNT_OUT_W'(cnt_r);
      out_empty_r  <= empty;
      out_full_r   <= full;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data        = out_data_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap)
    else $error("stored count above capacity");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside response state");

  a_search_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.command == CMD_SEARCH && !empty) |=> state_r == ST_SCAN)
    else $error("search on non-empty deque did not walk");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr && !(accept && in_ch.command == CMD_CLEAR)) |=>
      (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
       cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("stored count jumped");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> issued_r <= cnt_r)
    else $error("search walked past stored words");

endmodule

>>> hdl/circular_deque_unit.sv
// circular deque top level: capacity register port and command sequencer
//
//   channel  direction  handshake               payload
//   in_ch    sink       valid/ready             command, value
//   out_ch   source     valid/ready             status, data, found_index, count,
//                                               is_empty, is_full
//   cfg_     slave      psel/penable, pready=1  capacity_in_use at byte address 0
//
// push, pop, peek and clear update the indices and touch the ring on acceptance;
// the response step then loads the result register from the registered ring read.
// search walks from the front: the shared index stepper and the single ring read
// port visit one stored word per cycle, each compared in the cycle after its read.
// reset clears indices and count and sets the capacity (64, limited to DEPTH); the ring
// contents are left as they are, with no clearing pass.
// a held result does not stop acceptance of the next command; the result
// register only stalls the sequencer at its response step.
module circular_deque_unit import cdq_pkg::*; #(
  parameter int DEPTH      = CDQ_DEPTH,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  cdq_cmd_if.sink            in_ch,
  cdq_res_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_RST = (int'(CAP_REG_RST) > DEPTH) ? DEPTH : int'(CAP_REG_RST);

  logic [CAP_REG_W-1:0] cap_reg_r;
  logic [CNT_W-1:0]     cap_r, cap_nxt;
  logic [IDX_W-1:0]     cap_last_r, cap_last_nxt;
  logic [0:0]           reg_idx;
  logic                 cfg_wr;
  int unsigned          wr_val, wr_cap;

  assign reg_idx    = cfg_paddr[PADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (reg_idx == REG_CAPACITY);

  // zero acts as one, anything above the ring depth as the depth
  always_comb begin
    wr_val = int'(cfg_pwdata[CAP_REG_W-1:0]);
    if (wr_val == 0) begin
      wr_cap = 1;
    end else if (wr_val > DEPTH) begin
      wr_cap = DEPTH;
    end else begin
      wr_cap = wr_val;
    end
    cap_nxt      = CNT_W'(wr_cap);
    cap_last_nxt = IDX_W'(wr_cap - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_reg_r  <= CAP_REG_RST;
      cap_r      <= CNT_W'(CAP_RST);
      cap_last_r <= IDX_W'(CAP_RST - 1);
    end else if (cfg_wr) begin
      cap_reg_r  <= cfg_pwdata[CAP_REG_W-1:0];
      cap_r      <= cap_nxt;
      cap_last_r <= cap_last_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == REG_CAPACITY) ? PDATA_W'(cap_reg_r) : '0;

  cdq_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap      (cap_r),
    .cap_last (cap_last_r),
    .clr      (cfg_wr),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

>>> verif/cdq_checker.sv
// scoreboard for the circular deque: mirrors the ring, predicts each result and compares
module cdq_checker import cdq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  cdq_cmd_if                 cmd_mon,
  cdq_res_if                 res_mon,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 search_hits,
  output int                 full_rejects,
  output int                 empty_rejects
);

  typedef struct packed {
    cdq_stat_e_t           status;
    logic [VAL_W-1:0]      data;
    logic [FIDX_W-1:0]     found_index;
    logic [CNT_OUT_W-1:0]  count;
    logic                  is_empty;
    logic                  is_full;
  } deque_result_t;

  deque_result_t        awaited_results [$];
  logic [VAL_W-1:0]     ring_mirror [CDQ_DEPTH];
  int                   front_mirror;
  int                   rear_mirror;
  int                   words_held;
  logic [CAP_REG_W-1:0] capacity_reg;

  // applies one command to the mirrored deque and returns the result it should give
  function automatic deque_result_t apply_command(input cdq_cmd_e_t cmd,
                                                  input logic [VAL_W-1:0] word);
    deque_result_t res;
    int cap;
    int idx;
    int k;
    bit full;
    bit empty;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > CDQ_DEPTH) ? CDQ_DEPTH : int'(capacity_reg);
    full = words_held >= cap;
    empty = words_held == 0;
    front_mirror = front_mirror % cap;
    rear_mirror = rear_mirror % cap;
    res = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          words_held++;
          front_mirror = (front_mirror == 0) ? cap - 1 : front_mirror - 1;
          ring_mirror[front_mirror] = word;
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          words_held++;
          ring_mirror[rear_mirror] = word;
          rear_mirror = (rear_mirror + 1 == cap) ? 0 : rear_mirror + 1;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data = ring_mirror[front_mirror];
          if (cmd == CMD_POP_FRONT) begin
            words_held--;
            front_mirror = (front_mirror + 1 >= cap) ? 0 : front_mirror + 1;
          end
        end
      end
      CMD_POP_REAR, CMD_PEEK_REAR: begin
        if (empty) begin
          res.status = STAT_EMPTY;
        end else begin
          // slot before the rear wraps to the top of the capacity in use
          idx = (rear_mirror == 0) ? cap - 1 : rear_mirror - 1;
          res.data = ring_mirror[idx];
          if (cmd == CMD_POP_REAR) begin
            words_held--;
            rear_mirror = idx;
          end
        end
      end
      CMD_SEARCH: begin
        res.status = STAT_MISS;
        for (k = 0; k < words_held && k < cap; k++) begin
          idx = (front_mirror + k) % cap;
          if (res.status == STAT_MISS && ring_mirror[idx] == word) begin
            res.status = STAT_OK;
            res.found_index = FIDX_W'(idx);
          end
        end
      end
      default: begin
        front_mirror = 0;
        rear_mirror = 0;
        words_held = 0;
      end
    endcase
    res.count = CNT_OUT_W'(words_held);
    res.is_empty = words_held == 0;
    res.is_full = words_held >= cap;
    return res;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    deque_result_t pred;
    if (!rst_n) begin
      capacity_reg = CAP_REG_RST;
      front_mirror = 0;
      rear_mirror = 0;
      words_held = 0;
      awaited_results.delete();
      fail_count <= 0;
      results_seen <= 0;
      search_hits <= 0;
      full_rejects <= 0;
      empty_rejects <= 0;
    end else begin
      // a capacity write also empties the deque
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[PADDR_W-1:2] == REG_CAPACITY) begin
        capacity_reg = cfg_pwdata[CAP_REG_W-1:0];
        front_mirror = 0;
        rear_mirror = 0;
        words_held = 0;
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        pred = apply_command(cmd_mon.command, cmd_mon.value);
        awaited_results.push_back(pred);
        if (cmd_mon.command == CMD_SEARCH && pred.status == STAT_OK)
          search_hits <= search_hits + 1;
      end
      if (res_mon.valid && res_mon.ready) begin
        got.status = res_mon.status;
        got.data = res_mon.data;
        got.found_index = res_mon.found_index;
        got.count = res_mon.count;
        got.is_empty = res_mon.is_empty;
        got.is_full = res_mon.is_full;
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("result transaction with nothing expected: %s",
                     $sformatf("status=%0d data=%h idx=%0d count=%0d",
                               got.status, got.data, got.found_index, got.count));
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (want.status == STAT_FULL)
            full_rejects <= full_rejects + 1;
          if (want.status == STAT_EMPTY)
            empty_rejects <= empty_rejects + 1;
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected st=%0d data=%h idx=%0d cnt=%0d e=%b f=%b, %s",
                       want.status, want.data, want.found_index, want.count,
                       want.is_empty, want.is_full,
                       $sformatf("actual st=%0d data=%h idx=%0d cnt=%0d e=%b f=%b",
                                 got.status, got.data, got.found_index, got.count,
                                 got.is_empty, got.is_full));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= awaited_results.size();
  end

endmodule

>>> verif/tb_circular_deque_unit.sv
// testbench top for circular_deque_unit: clock, reset, stimulus, idling and verdict
module tb_circular_deque_unit;
  import cdq_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  int fail_count;
  int pending;
  int results_seen;
  int search_hits;
  int full_rejects;
  int empty_rejects;
  int idle_cycles = 0;
  int settings_used = 0;
  bit steady = 1'b0;

  // recently pushed words, used as search keys so that searches hit
  logic [VAL_W-1:0] recent_words [16] = '{default: '0};
  int               recent_wr = 0;

  logic [CAP_REG_W-1:0] cap_plan [10] = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127,
                                          7'd5, 7'd65, 7'd16, 7'd100, 7'd8};

  cdq_cmd_if cmd_ch ();
  cdq_res_if res_ch ();

  circular_deque_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cdq_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_mon       (cmd_ch),
    .res_mon       (res_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .search_hits   (search_hits),
    .full_rejects  (full_rejects),
    .empty_rejects (empty_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(9, 0))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2: return '1;
      3: return '0;
      4, 5: return VAL_W'($urandom_range(7, 0));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_command(input cdq_cmd_e_t cmd, input logic [VAL_W-1:0] word);
    int gap;
    gap = steady ? 0 : $urandom_range(14, 0);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.command <= cmd;
    cmd_ch.value <= word;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      recent_words[recent_wr % 16] = word;
      recent_wr++;
    end
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_REG_W-1:0] cap);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CAPACITY_ADDR;
    cfg_pwdata <= PDATA_W'(cap);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings_used++;
  endtask

  // result side: random stall before each transaction, none while steady
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(14, 0);
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("circular_deque_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    int eff;
    int push_pct;
    int pop_pct;
    cdq_cmd_e_t cmd;
    logic [VAL_W-1:0] word;
    logic [CAP_REG_W-1:0] cap;

    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_PUSH_FRONT;
    cmd_ch.value = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity, then a write must empty the deque
    send_command(CMD_SEARCH, '0);
    send_command(CMD_PUSH_REAR, 32'h0000_0001);
    send_command(CMD_PUSH_FRONT, 32'h0000_0002);
    drain();
    write_capacity(7'd3);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_PEEK_REAR, '0);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    // rear index still zero here: peek must wrap to the last slot
    send_command(CMD_PEEK_REAR, '0);
    send_command(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_command(CMD_PUSH_REAR, 32'hffff_ffff);
    send_command(CMD_PUSH_FRONT, '0);
    send_command(CMD_PUSH_REAR, '0);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_PEEK_REAR, '0);
    send_command(CMD_SEARCH, 32'hffff_ffff);
    send_command(CMD_SEARCH, 32'h1234_5678);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_SEARCH, 32'h7fff_ffff);
    send_command(CMD_CLEAR, 32'hdead_beef);
    send_command(CMD_PEEK_FRONT, '0);
    send_command(CMD_PUSH_REAR, 32'h5555_5555);
    send_command(CMD_PUSH_FRONT, 32'haaaa_aaaa);
    send_command(CMD_SEARCH, 32'h5555_5555);

    for (ph = 0; ph < PHASES; ph++) begin
      cap = (ph < 10) ? cap_plan[ph] : CAP_REG_W'($urandom_range(64, 1));
      drain();
      write_capacity(cap);
      eff = (cap == 0) ? 1 : (cap > CDQ_DEPTH) ? CDQ_DEPTH : int'(cap);
      steady = (ph % 4 == 2);
      // fill toward full, churn, then drain toward empty
      for (n = 0; n < 2 * eff + 36; n++) begin
        if (n < eff + 8) begin
          push_pct = 80;
          pop_pct = 6;
        end else if (n < eff + 28) begin
          push_pct = 40;
          pop_pct = 35;
        end else begin
          push_pct = 10;
          pop_pct = 75;
        end
        if (n == eff + 8 && ph % 2 == 1)
          drain();
        r = $urandom_range(99, 0);
        word = pick_word();
        if (r < push_pct) begin
          cmd = $urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else if (r < push_pct + pop_pct) begin
          cmd = $urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT;
        end else if (r < push_pct + pop_pct + 10) begin
          cmd = $urandom_range(1, 0) ? CMD_PEEK_REAR : CMD_PEEK_FRONT;
        end else if (r < push_pct + pop_pct + 12) begin
          cmd = CMD_CLEAR;
        end else begin
          cmd = CMD_SEARCH;
          if ($urandom_range(2, 0) != 0)
            word = recent_words[$urandom_range(15, 0)];
        end
        send_command(cmd, word);
      end
    end

    steady = 1'b0;
    drain();
    // keep idling so that any stray result still shows before the verdict
    repeat (80) @(posedge clk);

    $display("%0d results checked under %0d capacity settings (zero, one, full depth, above depth)",
             results_seen, settings_used);
    $display("search hits %0d, pushes refused when full %0d, pops and peeks refused when empty %0d",
             search_hits, full_rejects, empty_rejects);
    if (fail_count == 0 && pending == 0) begin
      $display("circular_deque_unit verification clean");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("circular_deque_unit verification failed");
    end
    $finish;
  end

endmodule

>>> circular_deque_unit.f
hdl/cdq_pkg.sv
hdl/cdq_intf.sv
hdl/cdq_ring_mem.sv
hdl/cdq_index_unit.sv
hdl/cdq_seq.sv
hdl/circular_deque_unit.sv
verif/cdq_checker.sv
verif/tb_circular_deque_unit.sv
